>>> src/premultiplied_rgba_weighted_blend_assert.svh
// Assertion macros shared by the blend checker.
`ifndef PREMULTIPLIED_RGBA_WEIGHTED_BLEND_ASSERT_SVH
`define PREMULTIPLIED_RGBA_WEIGHTED_BLEND_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMRB_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PMRB_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pmrb_pkg.sv
// Shared widths, constants and types of the premultiplied RGBA blend.
package pmrb_pkg;

    // Field widths of one transfer.
    localparam int COLOR_W  = 32;
    localparam int WEIGHT_W = 18;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;

    // Default number of fraction bits in a weight.
    localparam int WEIGHT_FRAC_BITS_DEF = 14;

    // Largest channel value.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Datapath widths.
    localparam int CA_W    = 2 * CHAN_W;        // color times alpha, unsigned
    localparam int AW_W    = CHAN_W + WEIGHT_W; // alpha times weight, signed
    localparam int SSUM_W  = AW_W + 1;          // alpha sum, signed
    localparam int S_W     = AW_W;              // positive clamped alpha sum
    localparam int PC_W    = CA_W + WEIGHT_W;   // premultiplied times weight, signed
    localparam int PSUM_W  = PC_W + 1;          // channel numerator, signed
    localparam int PPLUS_W = PSUM_W + 1;        // numerator plus alpha sum, signed
    localparam int REM_W   = PC_W;              // divider partial remainder

    // Pipeline depth: five front stages, one per quotient bit, one rounding stage.
    localparam int DIV_STEPS   = CHAN_W;
    localparam int PRE_STAGES  = 5;
    localparam int PIPE_STAGES = PRE_STAGES + DIV_STEPS + 1;

    // Per-channel overrides that travel next to the division.
    typedef struct packed {
        logic zero;
        logic sat;
    } t_chan_flags;

endpackage

>>> src/pmrb_in_if.sv
// Input channel: two colors and two weights with a valid/ready handshake.
interface pmrb_in_if;
    import pmrb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COLOR_W-1:0]         first_color;
    logic [COLOR_W-1:0]         second_color;
    logic signed [WEIGHT_W-1:0] first_weight;
    logic signed [WEIGHT_W-1:0] second_weight;

    modport source (
        output valid, first_color, second_color, first_weight, second_weight,
        input  ready
    );

    modport sink (
        input  valid, first_color, second_color, first_weight, second_weight,
        output ready
    );
endinterface

>>> src/pmrb_out_if.sv
// Output channel: one blended color with a valid/ready handshake.
interface pmrb_out_if;
    import pmrb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] result_color;

    modport source (
        output valid, result_color,
        input  ready
    );

    modport sink (
        input  valid, result_color,
        output ready
    );
endinterface

>>> src/pmrb_chan_div.sv
// Pipelined restoring divider for one channel: one quotient bit per stage, then rounding.
module pmrb_chan_div (
    input  logic                           i_clk,
    input  logic [pmrb_pkg::DIV_STEPS:0]   i_en,
    input  logic [pmrb_pkg::REM_W-1:0]     i_rem,
    input  logic [pmrb_pkg::S_W-1:0]       i_div,
    input  pmrb_pkg::t_chan_flags          i_flags,
    output logic [pmrb_pkg::CHAN_W-1:0]    o_chan
);
    import pmrb_pkg::*;

    localparam int LAST = DIV_STEPS - 1;

    logic [REM_W-1:0]  r_rem [DIV_STEPS];
    logic [S_W-1:0]    r_div [DIV_STEPS];
    logic [CHAN_W-1:0] r_q   [DIV_STEPS];
    t_chan_flags       r_flg [DIV_STEPS];

    logic [S_W-1:0]    w_rem_last;
    logic              w_round_up;
    logic [CHAN_W-1:0] w_rounded;
    logic [CHAN_W-1:0] n_chan;
    logic [CHAN_W-1:0] r_chan;

    // One stage per quotient bit, most significant bit first.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - j;

        logic [REM_W-1:0]  w_rem_in;
        logic [S_W-1:0]    w_div_in;
        logic [CHAN_W-1:0] w_q_in;
        t_chan_flags       w_flg_in;
        logic [REM_W-1:0]  w_dsh;
        logic [REM_W-1:0]  w_diff;
        logic              w_take;

        if (j == 0) begin : g_first
            assign w_rem_in = i_rem;
            assign w_div_in = i_div;
            assign w_q_in   = '0;
            assign w_flg_in = i_flags;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_div_in = r_div[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_flg_in = r_flg[j-1];
        end

        // Trial subtract of the shifted divisor.
        assign w_dsh  = REM_W'(w_div_in) << BIT;
        assign w_take = w_rem_in >= w_dsh;
        assign w_diff = w_rem_in - w_dsh;

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= w_take ? w_diff : w_rem_in;
                r_div[j] <= w_div_in;
                r_q[j]   <= w_q_in | (w_take ? (CHAN_W'(1) << BIT) : '0);
                r_flg[j] <= w_flg_in;
            end
        end
    end

    // Round half up: add one when twice the remainder reaches the divisor.
    assign w_rem_last = r_rem[LAST][S_W-1:0];
    assign w_round_up = {w_rem_last, 1'b0} >= {1'b0, r_div[LAST]};
    assign w_rounded  = r_q[LAST] + CHAN_W'(w_round_up);

    // A non-positive numerator or alpha sum gives zero, a quotient at full scale saturates.
    always_comb begin
        priority if (r_flg[LAST].zero) begin
            n_chan = '0;
        end else if (r_flg[LAST].sat) begin
            n_chan = CHAN_MAX;
        end else begin
            n_chan = w_rounded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STEPS]) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

>>> src/premultiplied_rgba_weighted_blend.sv
// Top level of the premultiplied RGBA weighted blend pipeline.
//
//   Channel   Dir  Handshake          Payload
//   i_in      in   valid / ready      first_color, second_color, first_weight, second_weight
//   o_out     out  valid / ready      result_color
//
// One transfer enters per clock while the output is not stalled; a result passes through
// five arithmetic stages, eight divider stages of one quotient bit each and one rounding
// stage that is also the output register.
// Synchronous active-low reset clears only the valid bits.
// A stall at the output holds the last stage; earlier stages keep moving into empty
// slots, so bubbles close up and nothing is lost or repeated.
module premultiplied_rgba_weighted_blend #(
    parameter int WEIGHT_FRAC_BITS = pmrb_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmrb_in_if.sink     i_in,
    pmrb_out_if.source  o_out
);
    import pmrb_pkg::*;

    // Full-scale alpha sum and the rounding constant for result alpha.
    localparam int FULL_W = CHAN_W + WEIGHT_FRAC_BITS;
    localparam int CMP_W  = ((FULL_W > SSUM_W) ? FULL_W : SSUM_W) + 1;
    localparam logic [CMP_W-1:0] FULL_EXT   = CMP_W'(CHAN_MAX) << WEIGHT_FRAC_BITS;
    localparam logic [S_W:0]     ROUND_HALF = (S_W + 1)'(1) << (WEIGHT_FRAC_BITS - 1);
    localparam int ALPHA_ST = 2;
    localparam int LAST_ST  = PIPE_STAGES - 1;

    // Stage valid bits and advance enables.
    logic [PIPE_STAGES-1:0] r_v;
    logic [PIPE_STAGES-1:0] w_en;
    logic [PIPE_STAGES-1:0] w_vin;

    // Shared stage registers.
    logic signed [AW_W-1:0]     r_aw1;
    logic signed [AW_W-1:0]     r_aw2;
    logic signed [WEIGHT_W-1:0] r_w1;
    logic signed [WEIGHT_W-1:0] r_w2;
    logic signed [SSUM_W-1:0]   r_ssum;
    logic [S_W-1:0]             r_sc2;
    logic                       r_spos2;
    logic [S_W-1:0]             r_sc3;
    logic [S_W-1:0]             r_sc4;
    logic [CHAN_W-1:0]          r_alpha [ALPHA_ST:LAST_ST];

    logic [CHAN_W-1:0]          w_a1;
    logic [CHAN_W-1:0]          w_a2;
    logic signed [AW_W-1:0]     w_aw1;
    logic signed [AW_W-1:0]     w_aw2;
    logic                       w_spos;
    logic [CMP_W-1:0]           w_sext;
    logic [S_W-1:0]             w_sc;
    logic [S_W:0]               w_alpha_sum;
    logic [S_W:0]               w_alpha_shr;
    logic [CHAN_W-1:0]          w_chan [NUM_CHAN];

    // Handshake: a stage moves when it is empty or the stage after it moves.
    assign w_en[LAST_ST] = !r_v[LAST_ST] || o_out.ready;
    for (genvar st = 0; st < LAST_ST; st++) begin : g_en
        assign w_en[st] = !r_v[st] || w_en[st+1];
    end

    assign w_vin      = {r_v[PIPE_STAGES-2:0], i_in.valid};
    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (w_en & w_vin) | (~w_en & r_v);
        end
    end

    // Stage 0: alpha times weight for the alpha sum.
    assign w_a1  = i_in.first_color[COLOR_W-1 -: CHAN_W];
    assign w_a2  = i_in.second_color[COLOR_W-1 -: CHAN_W];
    assign w_aw1 = $signed({{(AW_W-CHAN_W){1'b0}}, w_a1}) * AW_W'(i_in.first_weight);
    assign w_aw2 = $signed({{(AW_W-CHAN_W){1'b0}}, w_a2}) * AW_W'(i_in.second_weight);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_aw1 <= w_aw1;
            r_aw2 <= w_aw2;
            r_w1  <= i_in.first_weight;
            r_w2  <= i_in.second_weight;
        end
    end

    // Stage 1: alpha sum.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_ssum <= SSUM_W'(r_aw1) + SSUM_W'(r_aw2);
        end
    end

    // Stage 2: sign test, clamp to full scale and result alpha.
    assign w_spos      = !r_ssum[SSUM_W-1] && (r_ssum != '0);
    assign w_sext      = CMP_W'(r_ssum);
    assign w_sc        = (w_sext > FULL_EXT) ? S_W'(FULL_EXT) : S_W'(r_ssum);
    assign w_alpha_sum = {1'b0, w_sc} + ROUND_HALF;
    assign w_alpha_shr = w_alpha_sum >> WEIGHT_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_sc2             <= w_sc;
            r_spos2           <= w_spos;
            r_alpha[ALPHA_ST] <= w_spos ? w_alpha_shr[CHAN_W-1:0] : '0;
        end
    end

    // Stages 3 and 4 carry the clamped alpha sum toward the dividers.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sc3 <= r_sc2;
        end
        if (w_en[4]) begin
            r_sc4 <= r_sc3;
        end
    end

    // Result alpha rides along with the channel divisions.
    for (genvar st = ALPHA_ST + 1; st < PIPE_STAGES; st++) begin : g_alpha
        always_ff @(posedge i_clk) begin
            if (w_en[st]) begin
                r_alpha[st] <= r_alpha[st-1];
            end
        end
    end

    // Per-channel numerator, overrides and division.
    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
        logic [CHAN_W-1:0]        w_c1;
        logic [CHAN_W-1:0]        w_c2;
        logic [CA_W-1:0]          r_ca1;
        logic [CA_W-1:0]          r_ca2;
        logic signed [PC_W-1:0]   r_pc1;
        logic signed [PC_W-1:0]   r_pc2;
        logic signed [PSUM_W-1:0] r_psum;
        logic signed [PPLUS_W-1:0] r_pplus;
        logic [REM_W-1:0]         r_rem3;
        logic                     r_zero3;
        logic [REM_W-1:0]         r_rem4;
        t_chan_flags              r_flg4;
        logic                     w_nonpos;
        logic signed [PPLUS_W-1:0] w_s256;
        logic                     w_sat;

        assign w_c1 = i_in.first_color[k*CHAN_W +: CHAN_W];
        assign w_c2 = i_in.second_color[k*CHAN_W +: CHAN_W];

        // Stage 0: premultiply each color by its alpha.
        always_ff @(posedge i_clk) begin
            if (w_en[0]) begin
                r_ca1 <= {{CHAN_W{1'b0}}, w_c1} * {{CHAN_W{1'b0}}, w_a1};
                r_ca2 <= {{CHAN_W{1'b0}}, w_c2} * {{CHAN_W{1'b0}}, w_a2};
            end
        end

        // Stage 1: weight the premultiplied values.
        always_ff @(posedge i_clk) begin
            if (w_en[1]) begin
                r_pc1 <= $signed({{(PC_W-CA_W){1'b0}}, r_ca1}) * PC_W'(r_w1);
                r_pc2 <= $signed({{(PC_W-CA_W){1'b0}}, r_ca2}) * PC_W'(r_w2);
            end
        end

        // Stage 2: channel numerator.
        always_ff @(posedge i_clk) begin
            if (w_en[2]) begin
                r_psum <= PSUM_W'(r_pc1) + PSUM_W'(r_pc2);
            end
        end

        // Stage 3: zero test, and numerator plus alpha sum for the saturation test.
        assign w_nonpos = r_psum[PSUM_W-1] || (r_psum == '0);

        always_ff @(posedge i_clk) begin
            if (w_en[3]) begin
                r_zero3 <= !r_spos2 || w_nonpos;
                r_pplus <= PPLUS_W'(r_psum) + PPLUS_W'(r_sc2);
                r_rem3  <= r_psum[REM_W-1:0];
            end
        end

        // Stage 4: the quotient saturates when P + S reaches 256 * S.
        assign w_s256 = $signed({2'b00, r_sc3, {CHAN_W{1'b0}}});
        assign w_sat  = r_pplus >= w_s256;

        always_ff @(posedge i_clk) begin
            if (w_en[4]) begin
                r_rem4      <= r_rem3;
                r_flg4.zero <= r_zero3;
                r_flg4.sat  <= w_sat;
            end
        end

        pmrb_chan_div u_div (
            .i_clk   (i_clk),
            .i_en    (w_en[LAST_ST:PRE_STAGES]),
            .i_rem   (r_rem4),
            .i_div   (r_sc4),
            .i_flags (r_flg4),
            .o_chan  (w_chan[k])
        );
    end

    // Output register is the last stage of each divider and of the alpha line.
    assign o_out.valid        = r_v[LAST_ST];
    assign o_out.result_color = {r_alpha[LAST_ST], w_chan[2], w_chan[1], w_chan[0]};

endmodule

>>> src/pmrb_checker.sv
// Port-level checker for the blend pipeline and its bind to the top level.
`include "premultiplied_rgba_weighted_blend_assert.svh"

module pmrb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [pmrb_pkg::COLOR_W-1:0]   i_result_color
);
    import pmrb_pkg::*;

    localparam int CNT_W = $clog2(PIPE_STAGES + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_in_xfer;
    logic             w_out_xfer;

    // Count transfers that entered and have not yet left.
    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;
    assign n_cnt      = r_cnt + CNT_W'(w_in_xfer) - CNT_W'(w_out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Reset empties the pipeline.
    `PMRB_ASSERT_NEXT_NORST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

    // The input is only held off by a result that waits at the output.
    `PMRB_ASSERT(a_ready_when_free, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "input stalled without output backpressure")

    // A waiting result stays put.
    `PMRB_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_result_color), "waiting result changed")

    // Every result belongs to an input transfer still in flight.
    `PMRB_ASSERT(a_no_invented, i_clk, i_rst_n, i_out_valid, (r_cnt != '0) && (r_cnt <= CNT_W'(PIPE_STAGES)), "result without matching input")

endmodule

bind premultiplied_rgba_weighted_blend pmrb_checker u_pmrb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_color (o_out.result_color)
);
